/* sv/segment_circle_obstacle_check_defines.svh */
// Assertion macros shared by the segment and circle obstacle checker.
`ifndef SEGMENT_CIRCLE_OBSTACLE_CHECK_DEFINES_SVH
`define SEGMENT_CIRCLE_OBSTACLE_CHECK_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/scc_pkg.sv */
// Types and constants shared by the obstacle checker modules.
package scc_pkg;

   localparam int SLOT_BITS  = 4;
   localparam int COUNT_BITS = 5;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Control that travels with every request along the chain.
   typedef struct packed {
      logic                 valid;
      logic                 query;
      logic [SLOT_BITS-1:0] slot;
      logic                 blocked;
   } ctl_type;

endpackage

/* sv/scc_cell.sv */
// One chain cell: holds one obstacle and tests each passing segment against it.
module scc_cell #(
   parameter int COORD_BITS = 16,
   parameter int INDEX      = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [scc_pkg::COUNT_BITS-1:0]        count,
   input  scc_pkg::ctl_type                      in_ctl,
   input  logic signed [COORD_BITS-1:0]          in_obs_x,
   input  logic signed [COORD_BITS-1:0]          in_obs_y,
   input  logic        [COORD_BITS-2:0]          in_obs_r,
   input  logic signed [COORD_BITS-1:0]          in_px,
   input  logic signed [COORD_BITS-1:0]          in_py,
   input  logic signed [COORD_BITS:0]            in_dx,
   input  logic signed [COORD_BITS:0]            in_dy,
   output scc_pkg::ctl_type                      out_ctl,
   output logic signed [COORD_BITS-1:0]          out_obs_x,
   output logic signed [COORD_BITS-1:0]          out_obs_y,
   output logic        [COORD_BITS-2:0]          out_obs_r,
   output logic signed [COORD_BITS-1:0]          out_px,
   output logic signed [COORD_BITS-1:0]          out_py,
   output logic signed [COORD_BITS:0]            out_dx,
   output logic signed [COORD_BITS:0]            out_dy
);

   localparam int C   = COORD_BITS;
   localparam int DW  = C + 1;
   localparam int PW  = 2 * DW;
   localparam int RW  = 2 * C - 2;
   localparam int M   = 2 * C + 1;
   localparam int SW  = M + 1;
   localparam int GW  = M + 3;
   localparam int H   = C + 1;
   localparam int HI  = M - H;
   localparam int L   = 5;
   localparam logic [31:0] CellIdx = 32'(INDEX);

   // Obstacle held by this cell.
   logic signed [C-1:0] ox_ff, oy_ff;
   logic        [C-2:0] or_ff;

   // Delay lines that keep each request aligned with the arithmetic.
   scc_pkg::ctl_type    ctl_ff [L];
   logic signed [C-1:0] wx_ff  [L];
   logic signed [C-1:0] wy_ff  [L];
   logic        [C-2:0] wr_ff  [L];
   logic signed [C-1:0] px_ff  [L];
   logic signed [C-1:0] py_ff  [L];
   logic signed [DW-1:0] dx_ff [L];
   logic signed [DW-1:0] dy_ff [L];

   logic signed [DW-1:0] fx_ff, fy_ff, fx_in, fy_in;
   logic        [C-2:0]  r1_ff;
   logic signed [PW-1:0] fdx_ff, fdy_ff, ffx_ff, ffy_ff, ddx_ff, ddy_ff;
   logic        [RW-1:0] rr_ff;
   logic        [M-1:0]  a3_ff, a3_in;
   logic signed [SW-1:0] bh3_ff, bh3_in, c3_ff, c3_in;
   logic signed [GW-1:0] a_g, bh_g, c_g, g1;
   logic        [SW-1:0] nb_w;
   logic        [M-1:0]  nb;
   logic                 a_zero, c_le, c_neg, g1_le, g1_neg, bh_nonneg, nb_ge_a;
   logic                 dec4_in, dhit4_in, dec4_ff, dhit4_ff, dec5_ff, dhit5_ff;
   logic [2*H-1:0]       pll_ff, qll_ff;
   logic [M-1:0]         plh_ff, qlh_ff, qhl_ff;
   logic [2*HI-1:0]      phh_ff, qhh_ff;
   logic [2*M-1:0]       psq_ff, qsq_ff, psq_in, qsq_in;
   logic                 hit, active, load_obs;

   assign load_obs = advance && in_ctl.valid && (in_ctl.query == scc_pkg::FUNC_WRITE)
                     && (32'(in_ctl.slot) == CellIdx);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (advance) begin
         ctl_ff[0] <= in_ctl;
         for (int k = 1; k < L; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_obs) begin
         ox_ff <= in_obs_x;
         oy_ff <= in_obs_y;
         or_ff <= in_obs_r;
      end
   end

   // Stage one.
   assign fx_in = DW'(in_px) - DW'(ox_ff);
   assign fy_in = DW'(in_py) - DW'(oy_ff);

   // Stage three.
   assign a3_in  = M'(ddx_ff) + M'(ddy_ff);
   assign bh3_in = SW'(fdx_ff) + SW'(fdy_ff);
   assign c3_in  = SW'(ffx_ff) + SW'(ffy_ff) - SW'(rr_ff);

   // Stage four: sign tests settle most cases; the rest need b^2 >= 4ac.
   assign a_g       = GW'(a3_ff);
   assign bh_g      = GW'(bh3_ff);
   assign c_g       = GW'(c3_ff);
   assign g1        = a_g + (bh_g <<< 1) + c_g;
   assign nb_w      = -bh3_ff;
   assign nb        = nb_w[M-1:0];
   assign a_zero    = (a3_ff == '0);
   assign c_neg     = c3_ff[SW-1];
   assign c_le      = c_neg || (c3_ff == '0);
   assign g1_neg    = g1[GW-1];
   assign g1_le     = g1_neg || (g1 == '0);
   assign bh_nonneg = !bh3_ff[SW-1];
   assign nb_ge_a   = (nb >= a3_ff);

   always_comb begin
      dec4_in  = 1'b1;
      dhit4_in = 1'b0;
      priority if (a_zero) begin
         dhit4_in = c_le;
      end else if (c_neg && g1_neg) begin
         dhit4_in = 1'b0;
      end else if (bh_nonneg) begin
         dhit4_in = c_le;
      end else if (nb_ge_a) begin
         dhit4_in = g1_le;
      end else if (c_le) begin
         dhit4_in = 1'b1;
      end else begin
         dec4_in = 1'b0;
      end
   end

   // Stage five: assemble the wide square and the wide product from their partial products.
   assign psq_in = ((2*M)'(phh_ff) << (2*H)) + ((2*M)'(plh_ff) << (H+1))
                   + (2*M)'(pll_ff);
   assign qsq_in = ((2*M)'(qhh_ff) << (2*H))
                   + (((2*M)'(qlh_ff) + (2*M)'(qhl_ff)) << H) + (2*M)'(qll_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff[0] <= in_obs_x;
         wy_ff[0] <= in_obs_y;
         wr_ff[0] <= in_obs_r;
         px_ff[0] <= in_px;
         py_ff[0] <= in_py;
         dx_ff[0] <= in_dx;
         dy_ff[0] <= in_dy;
         for (int k = 1; k < L; k++) begin
            wx_ff[k] <= wx_ff[k-1];
            wy_ff[k] <= wy_ff[k-1];
            wr_ff[k] <= wr_ff[k-1];
            px_ff[k] <= px_ff[k-1];
            py_ff[k] <= py_ff[k-1];
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
         end
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
         r1_ff    <= or_ff;
         fdx_ff   <= PW'(fx_ff) * PW'(dx_ff[0]);
         fdy_ff   <= PW'(fy_ff) * PW'(dy_ff[0]);
         ffx_ff   <= PW'(fx_ff) * PW'(fx_ff);
         ffy_ff   <= PW'(fy_ff) * PW'(fy_ff);
         ddx_ff   <= PW'(dx_ff[0]) * PW'(dx_ff[0]);
         ddy_ff   <= PW'(dy_ff[0]) * PW'(dy_ff[0]);
         rr_ff    <= RW'(r1_ff) * RW'(r1_ff);
         a3_ff    <= a3_in;
         bh3_ff   <= bh3_in;
         c3_ff    <= c3_in;
         dec4_ff  <= dec4_in;
         dhit4_ff <= dhit4_in;
         pll_ff   <= (2*H)'(nb[H-1:0]) * (2*H)'(nb[H-1:0]);
         plh_ff   <= M'(nb[H-1:0]) * M'(nb[M-1:H]);
         phh_ff   <= (2*HI)'(nb[M-1:H]) * (2*HI)'(nb[M-1:H]);
         qll_ff   <= (2*H)'(a3_ff[H-1:0]) * (2*H)'(c3_ff[H-1:0]);
         qlh_ff   <= M'(a3_ff[H-1:0]) * M'(c3_ff[M-1:H]);
         qhl_ff   <= M'(a3_ff[M-1:H]) * M'(c3_ff[H-1:0]);
         qhh_ff   <= (2*HI)'(a3_ff[M-1:H]) * (2*HI)'(c3_ff[M-1:H]);
         dec5_ff  <= dec4_ff;
         dhit5_ff <= dhit4_ff;
         psq_ff   <= psq_in;
         qsq_ff   <= qsq_in;
      end
   end

   assign hit    = dec5_ff ? dhit5_ff : (psq_ff >= qsq_ff);
   assign active = (32'(count) > CellIdx);

   always_comb begin
      out_ctl         = ctl_ff[L-1];
      out_ctl.blocked = ctl_ff[L-1].blocked
                        || (ctl_ff[L-1].query && active && hit);
   end

   assign out_obs_x = wx_ff[L-1];
   assign out_obs_y = wy_ff[L-1];
   assign out_obs_r = wr_ff[L-1];
   assign out_px    = px_ff[L-1];
   assign out_py    = py_ff[L-1];
   assign out_dx    = dx_ff[L-1];
   assign out_dy    = dy_ff[L-1];

endmodule

/* sv/segment_circle_obstacle_check.sv */
// Top level: checks segments against a chain of circular obstacles.
// Throughput: one request per cycle while the chain advances; each cell is a five-stage pipeline.
// The chain stalls only while a finished result waits at the output.
// Synchronous reset clears the pipeline control, the result valid flag and the count.
// Obstacle slots hold no reset value and must be written before use.
`include "segment_circle_obstacle_check_defines.svh"
module segment_circle_obstacle_check #(
   parameter int MAX_OBSTACLES = 16,
   parameter int COORD_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [scc_pkg::SLOT_BITS-1:0]        req_slot,
   input  logic signed [COORD_BITS-1:0]         req_obs_x,
   input  logic signed [COORD_BITS-1:0]         req_obs_y,
   input  logic        [COORD_BITS-2:0]         req_obs_radius,
   input  logic signed [COORD_BITS-1:0]         req_from_x,
   input  logic signed [COORD_BITS-1:0]         req_from_y,
   input  logic signed [COORD_BITS-1:0]         req_to_x,
   input  logic signed [COORD_BITS-1:0]         req_to_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_path_clear,
   input  logic                                 csr_wr_en,
   input  logic [scc_pkg::COUNT_BITS-1:0]       csr_wr_data
);

   localparam int C  = COORD_BITS;
   localparam int N  = MAX_OBSTACLES;

   logic [scc_pkg::COUNT_BITS-1:0] count_ff;
   logic                           rsp_valid_ff, rsp_clear_ff;
   logic                           advance;

   scc_pkg::ctl_type     ch_ctl [N+1];
   logic signed [C-1:0]  ch_wx  [N+1];
   logic signed [C-1:0]  ch_wy  [N+1];
   logic        [C-2:0]  ch_wr  [N+1];
   logic signed [C-1:0]  ch_px  [N+1];
   logic signed [C-1:0]  ch_py  [N+1];
   logic signed [C:0]    ch_dx  [N+1];
   logic signed [C:0]    ch_dy  [N+1];

   scc_pkg::ctl_type     front_ctl_ff, front_ctl_in, tail;

   assign tail      = ch_ctl[N];
   // The chain holds only when a finished query cannot leave.
   assign advance   = !(tail.valid && tail.query && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      front_ctl_in.valid   = req_valid;
      front_ctl_in.query   = (req_func == scc_pkg::FUNC_QUERY);
      front_ctl_in.slot    = req_slot;
      front_ctl_in.blocked = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ctl_ff <= '0;
      end else if (advance) begin
         front_ctl_ff <= front_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ch_wx[0] <= req_obs_x;
         ch_wy[0] <= req_obs_y;
         ch_wr[0] <= req_obs_radius;
         ch_px[0] <= req_from_x;
         ch_py[0] <= req_from_y;
         ch_dx[0] <= (C+1)'(req_to_x) - (C+1)'(req_from_x);
         ch_dy[0] <= (C+1)'(req_to_y) - (C+1)'(req_from_y);
      end
   end

   assign ch_ctl[0] = front_ctl_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      scc_cell #(
         .COORD_BITS (COORD_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .count     (count_ff),
         .in_ctl    (ch_ctl[i]),
         .in_obs_x  (ch_wx[i]),
         .in_obs_y  (ch_wy[i]),
         .in_obs_r  (ch_wr[i]),
         .in_px     (ch_px[i]),
         .in_py     (ch_py[i]),
         .in_dx     (ch_dx[i]),
         .in_dy     (ch_dy[i]),
         .out_ctl   (ch_ctl[i+1]),
         .out_obs_x (ch_wx[i+1]),
         .out_obs_y (ch_wy[i+1]),
         .out_obs_r (ch_wr[i+1]),
         .out_px    (ch_px[i+1]),
         .out_py    (ch_py[i+1]),
         .out_dx    (ch_dx[i+1]),
         .out_dy    (ch_dy[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail.valid && tail.query) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.valid && tail.query) begin
         rsp_clear_ff <= !tail.blocked;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_clear = rsp_clear_ff;

   `ASSERT_IMPL(a_stall_holds_input, clock, reset,
      rsp_valid_ff && !rsp_ready && tail.valid && tail.query, !req_ready)
   `ASSERT_NEXT(a_write_gives_no_result, clock, reset,
      tail.valid && !tail.query && !rsp_valid_ff, !rsp_valid_ff)
   `ASSERT_NEXT(a_query_gives_result, clock, reset,
      advance && tail.valid && tail.query, rsp_valid_ff)

endmodule
